### rtl/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg
// shared widths, register codes, controller states and command structs
// for the masked pair covariance core
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 12;

  localparam int SAMPLE_W   = 24;
  localparam int TOL_W      = 23;
  localparam int PAIR_W     = 2 * SAMPLE_W;                 // one sample product
  localparam int SUM_W      = 40;                           // first and second sums
  localparam int SPROD_W    = 64;                           // sum of products
  localparam int WIDE_W     = 80;                           // n*p and a*b terms
  localparam int DEN_W      = 2 * COUNT_BITS + FRAC_BITS;   // n*n scaled
  localparam int COV_W      = 40;
  localparam int PCOUNT_W   = 16;

  localparam int MUL_STEPS  = SUM_W;                        // multiplier bits
  localparam int DIV_STEPS  = WIDE_W;                       // quotient bits
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [SAMPLE_W-1:0] SENTINEL_RESET = SAMPLE_W'(65 << FRAC_BITS);
  localparam logic [TOL_W-1:0]    TOL_RESET      =
    TOL_W'(((1 << FRAC_BITS) + 500) / 1000);

  // saturation limits, as magnitudes of the quotient
  localparam logic [WIDE_W-1:0] POS_LIMIT_MAG = (WIDE_W'(1) << (COV_W - 1)) - WIDE_W'(1);
  localparam logic [WIDE_W-1:0] NEG_LIMIT_MAG = WIDE_W'(1) << (COV_W - 1);
  localparam logic [COV_W-1:0]  COV_POS_LIMIT = {1'b0, {(COV_W-1){1'b1}}};
  localparam logic [COV_W-1:0]  COV_NEG_LIMIT = {1'b1, {(COV_W-1){1'b0}}};

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENTINEL_VALUE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENTINEL_TOL   = 1'b1;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_LD_NP,
    ST_MUL_NP,
    ST_LD_AB,
    ST_MUL_AB,
    ST_DIFF,
    ST_DIV_LD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take_in;     // input side open
    logic mul_ld_np;   // load n * sum_product, latch n*n
    logic mul_ld_ab;   // store n*p term, load sum_first * sum_second
    logic mul_step;    // one shift-add step
    logic diff;        // form n*p - a*b
    logic div_ld;      // load magnitude into divider
    logic div_step;    // one restoring divide step
    logic finish;      // saturate into output register, clear run
  } ctl_cmd_t;

  typedef struct packed {
    logic last_pending;  // final pair sits in the input stage register
    logic mul_last;      // current multiply step is the final one
    logic div_last;      // current divide step is the final one
    logic out_busy;      // output register full and stalled
  } ctl_sts_t;

endpackage

### rtl/mpc_ctrl.sv
// ----------------------------------------------------------------------------
// mpc_ctrl
// sequencer for the accumulate, multiply, divide and output phases
// ----------------------------------------------------------------------------
module mpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  mpc_pkg::ctl_sts_t sts,
  output mpc_pkg::ctl_cmd_t cmd
);

  mpc_pkg::state_t state_r;
  mpc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpc_pkg::ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpc_pkg::ST_ACC:    if (sts.last_pending) state_nxt = mpc_pkg::ST_LD_NP;
      mpc_pkg::ST_LD_NP:  state_nxt = mpc_pkg::ST_MUL_NP;
      mpc_pkg::ST_MUL_NP: if (sts.mul_last) state_nxt = mpc_pkg::ST_LD_AB;
      mpc_pkg::ST_LD_AB:  state_nxt = mpc_pkg::ST_MUL_AB;
      mpc_pkg::ST_MUL_AB: if (sts.mul_last) state_nxt = mpc_pkg::ST_DIFF;
      mpc_pkg::ST_DIFF:   state_nxt = mpc_pkg::ST_DIV_LD;
      mpc_pkg::ST_DIV_LD: state_nxt = mpc_pkg::ST_DIV;
      mpc_pkg::ST_DIV:    if (sts.div_last) state_nxt = mpc_pkg::ST_DONE;
      mpc_pkg::ST_DONE:   if (!sts.out_busy) state_nxt = mpc_pkg::ST_ACC;
      default:            state_nxt = mpc_pkg::ST_ACC;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      mpc_pkg::ST_ACC:    cmd.take_in   = !sts.last_pending;
      mpc_pkg::ST_LD_NP:  cmd.mul_ld_np = 1'b1;
      mpc_pkg::ST_MUL_NP: cmd.mul_step  = 1'b1;
      mpc_pkg::ST_LD_AB:  cmd.mul_ld_ab = 1'b1;
      mpc_pkg::ST_MUL_AB: cmd.mul_step  = 1'b1;
      mpc_pkg::ST_DIFF:   cmd.diff      = 1'b1;
      mpc_pkg::ST_DIV_LD: cmd.div_ld    = 1'b1;
      mpc_pkg::ST_DIV:    cmd.div_step  = 1'b1;
      mpc_pkg::ST_DONE:   cmd.finish    = !sts.out_busy;
      default:            cmd = '0;
    endcase
  end

  // a final pair always hands over to the n*p load
  a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mpc_pkg::ST_ACC && sts.last_pending) |=> (state_r == mpc_pkg::ST_LD_NP))
    else $error("final pair did not start the covariance sequence");

  // no new pair enters behind a pending final pair
  a_no_take_behind_last: assert property (@(posedge clk) disable iff (!rst_n)
    sts.last_pending |-> !cmd.take_in)
    else $error("input taken while final pair pending");

  // the output register is never overwritten while its beat is stalled
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !sts.out_busy)
    else $error("result written over a stalled beat");

  // the second multiply ends in the subtract phase
  a_mul_ab_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mpc_pkg::ST_MUL_AB && sts.mul_last) |=> cmd.diff)
    else $error("a*b multiply did not hand over to subtract");

endmodule

### rtl/mpc_datapath.sv
// ----------------------------------------------------------------------------
// mpc_datapath
// sentinel registers, missing test, accumulators, shift-add multiplier,
// restoring divider and output register
// ----------------------------------------------------------------------------
module mpc_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mpc_pkg::ctl_cmd_t                    cmd,
  output mpc_pkg::ctl_sts_t                    sts,
  input  logic                                 cfg_we,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mpc_pkg::SAMPLE_W-1:0]         cfg_data,
  input  logic                                 in_valid,
  input  logic signed [mpc_pkg::SAMPLE_W-1:0]  in_sample_a,
  input  logic signed [mpc_pkg::SAMPLE_W-1:0]  in_sample_b,
  input  logic                                 in_a_is_nan,
  input  logic                                 in_b_is_nan,
  input  logic                                 in_last,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [mpc_pkg::COV_W-1:0]     out_covariance,
  output logic [mpc_pkg::PCOUNT_W-1:0]         out_pair_count,
  output logic                                 out_count_overflow
);

  localparam int SW  = mpc_pkg::SAMPLE_W;
  localparam int WW  = mpc_pkg::WIDE_W;
  localparam int DW  = mpc_pkg::DEN_W;
  localparam int CB  = mpc_pkg::COUNT_BITS;
  localparam int CB2 = 2 * CB;

  function automatic logic is_missing(input logic [SW-1:0] s, input logic nan,
                                      input logic [SW-1:0] sv,
                                      input logic [mpc_pkg::TOL_W-1:0] tol);
    logic [SW:0] d;
    logic [SW:0] m;
    d = {s[SW-1], s} - {sv[SW-1], sv};
    m = d[SW] ? (~d + (SW+1)'(1)) : d;
    return nan | (m <= (SW+1)'(tol));
  endfunction

  // configuration
  logic [SW-1:0]                 sentinel_r;
  logic [mpc_pkg::TOL_W-1:0]     tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sentinel_r <= mpc_pkg::SENTINEL_RESET;
      tol_r      <= mpc_pkg::TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mpc_pkg::CFG_SENTINEL_VALUE: sentinel_r <= cfg_data;
        mpc_pkg::CFG_SENTINEL_TOL:   tol_r      <= cfg_data[mpc_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage: missing test and sample product
  logic                          take;
  logic                          s0_valid_r;
  logic                          s0_present_r;
  logic                          s0_last_r;
  logic [SW-1:0]                 s0_a_r;
  logic [SW-1:0]                 s0_b_r;
  logic signed [mpc_pkg::PAIR_W-1:0] s0_prod_r;

  assign take = in_valid && cmd.take_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s0_present_r <= !is_missing(in_sample_a, in_a_is_nan, sentinel_r, tol_r) &&
                      !is_missing(in_sample_b, in_b_is_nan, sentinel_r, tol_r);
      s0_last_r    <= in_last;
      s0_a_r       <= in_sample_a;
      s0_b_r       <= in_sample_b;
      s0_prod_r    <= in_sample_a * in_sample_b;
    end
  end

  // accumulators
  logic [mpc_pkg::SUM_W-1:0]     sum_first_r;
  logic [mpc_pkg::SUM_W-1:0]     sum_second_r;
  logic [mpc_pkg::SPROD_W-1:0]   sum_product_r;
  logic [CB-1:0]                 count_r;
  logic                          ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      sum_first_r   <= '0;
      sum_second_r  <= '0;
      sum_product_r <= '0;
      count_r       <= '0;
      ovf_r         <= 1'b0;
    end else if (s0_valid_r && s0_present_r) begin
      if (count_r == mpc_pkg::COUNT_MAX) begin
        ovf_r <= 1'b1;
      end else begin
        count_r       <= count_r + CB'(1);
        sum_first_r   <= sum_first_r + mpc_pkg::SUM_W'(signed'(s0_a_r));
        sum_second_r  <= sum_second_r + mpc_pkg::SUM_W'(signed'(s0_b_r));
        sum_product_r <= sum_product_r + mpc_pkg::SPROD_W'(s0_prod_r);
      end
    end
  end

  // shift-add multiplier on magnitudes, shared by n*p and a*b
  logic [WW-1:0]                 mul_mc_r;
  logic [mpc_pkg::SUM_W-1:0]     mul_mp_r;
  logic [WW-1:0]                 mul_acc_r;
  logic                          mul_neg_r;
  logic [mpc_pkg::STEP_W-1:0]    step_r;
  logic [DW-1:0]                 den_r;
  logic [WW-1:0]                 np_r;
  logic [WW-1:0]                 d_r;
  logic [mpc_pkg::SPROD_W-1:0]   p_mag;
  logic [mpc_pkg::SUM_W-1:0]     a_mag;
  logic [mpc_pkg::SUM_W-1:0]     b_mag;

  assign p_mag = sum_product_r[mpc_pkg::SPROD_W-1] ? (~sum_product_r + mpc_pkg::SPROD_W'(1))
                                                    : sum_product_r;
  assign a_mag = sum_first_r[mpc_pkg::SUM_W-1] ? (~sum_first_r + mpc_pkg::SUM_W'(1))
                                               : sum_first_r;
  assign b_mag = sum_second_r[mpc_pkg::SUM_W-1] ? (~sum_second_r + mpc_pkg::SUM_W'(1))
                                                : sum_second_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_ld_np) begin
      mul_mc_r  <= WW'(p_mag);
      mul_mp_r  <= mpc_pkg::SUM_W'(count_r);
      mul_acc_r <= '0;
      mul_neg_r <= sum_product_r[mpc_pkg::SPROD_W-1];
      // n*n at full width, then scaled by the fraction
      den_r     <= {CB2'(count_r) * CB2'(count_r), {mpc_pkg::FRAC_BITS{1'b0}}};
    end else if (cmd.mul_ld_ab) begin
      np_r      <= mul_neg_r ? (~mul_acc_r + WW'(1)) : mul_acc_r;
      mul_mc_r  <= WW'(a_mag);
      mul_mp_r  <= b_mag;
      mul_acc_r <= '0;
      mul_neg_r <= sum_first_r[mpc_pkg::SUM_W-1] ^ sum_second_r[mpc_pkg::SUM_W-1];
    end else if (cmd.mul_step) begin
      if (mul_mp_r[0]) begin
        mul_acc_r <= mul_acc_r + mul_mc_r;
      end
      mul_mc_r <= {mul_mc_r[WW-2:0], 1'b0};
      mul_mp_r <= {1'b0, mul_mp_r[mpc_pkg::SUM_W-1:1]};
    end
  end

  // n*p - a*b, where a*b carries its sign in mul_neg_r
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      d_r <= np_r + (mul_neg_r ? mul_acc_r : ~mul_acc_r) + WW'(!mul_neg_r);
    end
  end

  // restoring divider, one quotient bit per step
  logic [WW-1:0]                 qd_r;
  logic [DW-1:0]                 rem_r;
  logic                          qneg_r;
  logic [DW:0]                   rsh;
  logic [DW:0]                   rsub;
  logic                          ge;

  assign rsh  = {rem_r, qd_r[WW-1]};
  assign rsub = rsh - {1'b0, den_r};
  assign ge   = (rsh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.div_ld) begin
      qd_r   <= d_r[WW-1] ? (~d_r + WW'(1)) : d_r;
      qneg_r <= d_r[WW-1];
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? rsub[DW-1:0] : rsh[DW-1:0];
      qd_r  <= {qd_r[WW-2:0], ge};
    end
  end

  // shared step counter
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.mul_ld_np || cmd.mul_ld_ab || cmd.div_ld) begin
      step_r <= '0;
    end else if (cmd.mul_step || cmd.div_step) begin
      step_r <= step_r + mpc_pkg::STEP_W'(1);
    end
  end

  // saturation and output register
  logic [mpc_pkg::COV_W-1:0]     cov_sat;
  logic                          out_valid_r;
  logic [mpc_pkg::COV_W-1:0]     cov_r;
  logic [mpc_pkg::PCOUNT_W-1:0]  pcount_r;
  logic                          ovf_out_r;

  always_comb begin
    if (count_r == '0) begin
      cov_sat = '0;
    end else if (qneg_r) begin
      cov_sat = (qd_r > mpc_pkg::NEG_LIMIT_MAG) ? mpc_pkg::COV_NEG_LIMIT
                                               : (~qd_r[mpc_pkg::COV_W-1:0] +
                                                  mpc_pkg::COV_W'(1));
    end else begin
      cov_sat = (qd_r > mpc_pkg::POS_LIMIT_MAG) ? mpc_pkg::COV_POS_LIMIT
                                               : qd_r[mpc_pkg::COV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cov_r     <= cov_sat;
      pcount_r  <= mpc_pkg::PCOUNT_W'(count_r);
      ovf_out_r <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_covariance     = cov_r;
  assign out_pair_count     = pcount_r;
  assign out_count_overflow = ovf_out_r;

  assign sts.last_pending = s0_valid_r && s0_last_r;
  assign sts.mul_last     = (step_r == mpc_pkg::STEP_W'(mpc_pkg::MUL_STEPS - 1));
  assign sts.div_last     = (step_r == mpc_pkg::STEP_W'(mpc_pkg::DIV_STEPS - 1));
  assign sts.out_busy     = out_valid_r && out_stall;

endmodule

### rtl/masked_pair_covariance_core.sv
// ----------------------------------------------------------------------------
// masked_pair_covariance_core
// covariance of sample pairs with missing values masked out
// ----------------------------------------------------------------------------
// usage
// - input beats carry one sample pair in signed q12.12 with nan flags and a
//   last marker; a beat moves when in_valid is high and in_stall is low
// - a sample is masked when its nan flag is set or it lies within the
//   tolerance of the sentinel (both set through the cfg write port)
// - pairs stream in at one beat per cycle while a run accumulates
// - the beat marked last closes the run: its result beat appears on the
//   out channel after one n*n latch, two 40-step shift-add multiplies,
//   the subtract and an 80-step restoring divide
// - during that sequence in_stall stays high, and the divide loop is its
//   longest part
// - the result beat holds in the output register while out_stall is high;
//   a following run accumulates meanwhile, and only the next run's result
//   waits for the register to drain
// - synchronous reset clears accumulators, the sequencer and the output
//   valid, and restores the sentinel (65.0) and tolerance (0.001)
// ----------------------------------------------------------------------------
module masked_pair_covariance_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mpc_pkg::SAMPLE_W-1:0]         cfg_data,
  // sample pair channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mpc_pkg::SAMPLE_W-1:0]  in_sample_a,
  input  logic signed [mpc_pkg::SAMPLE_W-1:0]  in_sample_b,
  input  logic                                 in_a_is_nan,
  input  logic                                 in_b_is_nan,
  input  logic                                 in_last,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mpc_pkg::COV_W-1:0]     out_covariance,
  output logic [mpc_pkg::PCOUNT_W-1:0]         out_pair_count,
  output logic                                 out_count_overflow
);

  mpc_pkg::ctl_cmd_t cmd;
  mpc_pkg::ctl_sts_t sts;

  // sequencer: accumulate, multiply, divide, hand over result
  mpc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // all arithmetic and storage
  mpc_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_sample_a        (in_sample_a),
    .in_sample_b        (in_sample_b),
    .in_a_is_nan        (in_a_is_nan),
    .in_b_is_nan        (in_b_is_nan),
    .in_last            (in_last),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_covariance     (out_covariance),
    .out_pair_count     (out_pair_count),
    .out_count_overflow (out_count_overflow)
  );

  // input side closes outside accumulation and behind a pending final pair
  assign in_stall = !cmd.take_in;

endmodule
